### hdl/obbp_pkg.sv
package obbp_pkg;

  typedef enum logic {
    ACT_ROTATE  = 1'b0,
    ACT_PROJECT = 1'b1
  } action_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_HALF_WIDTH  = 1'd0;
  localparam cfg_idx_t REG_HALF_HEIGHT = 1'd1;

  // pipeline depth, input register through result register
  localparam int STAGES       = 12;
  localparam int COMMIT_STAGE = 5;
  localparam int PROJ_STAGE   = 6;

  // sine polynomial coefficients, Q14
  localparam logic [10:0] SIN_C3 = 11'd1142;
  localparam logic [14:0] SIN_C2 = 15'd10476;
  localparam logic [15:0] SIN_C1 = 16'd25718;
  localparam logic [14:0] QUARTER = 15'd16384;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    action_t            action;
    logic [15:0]        angle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] first_axis_x;
    logic signed [15:0] first_axis_y;
    logic signed [15:0] second_axis_x;
    logic signed [15:0] second_axis_y;
  } item_t;

  typedef struct packed {
    logic signed [31:0] span_a_min;
    logic signed [31:0] span_a_max;
    logic signed [31:0] span_b_min;
    logic signed [31:0] span_b_max;
    logic [3:0]         mask_a_min;
    logic [3:0]         mask_a_max;
    logic [3:0]         mask_b_min;
    logic [3:0]         mask_b_max;
    logic signed [31:0] local_left;
    logic signed [31:0] local_right;
    logic signed [31:0] local_bottom;
    logic signed [31:0] local_top;
  } res_t;

  // per-item data that rides alongside the trig and corner stages
  typedef struct packed {
    action_t            action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] first_axis_x;
    logic signed [15:0] first_axis_y;
    logic signed [15:0] second_axis_x;
    logic signed [15:0] second_axis_y;
  } side_t;

  typedef struct packed {
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] d_x;
    logic signed [31:0] d_y;
  } corners_t;

  // round a Q.14-extended value to nearest and saturate to 32 bits
  function automatic logic signed [31:0] rnd14(input logic signed [49:0] v);
    logic signed [49:0] t;
    t = (v + 50'sd8192) >>> 14;
    if (t[49:31] != {19{t[49]}}) begin
      return t[49] ? SAT_MIN : SAT_MAX;
    end
    return t[31:0];
  endfunction

endpackage

### hdl/obbp_if.sv
interface obbp_item_if;
  import obbp_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface obbp_res_if;
  import obbp_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface obbp_cfg_if;
  import obbp_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/oriented_box_bounds_and_projection_top.sv
// Path: an accepted item passes the input register, trig stages, corner products, stored
//   corners and projection stages before its result reaches the output register.
// Throughput: one item per cycle; the 12-stage pipeline holds as a whole while a result waits.
// Corners are written at stage 5 and read at stage 6, so back-to-back rotate/project is safe.
// Reset (rst, synchronous): clears valid bits, half sizes and stored corners to zero.
module oriented_box_bounds_and_projection_top #(
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  obbp_cfg_if.sink    cfg,
  obbp_item_if.sink   item,
  obbp_res_if.source  result
);
  import obbp_pkg::*;

  logic [30:0]        half_width, half_height;
  logic               en, commit;
  logic [STAGES-1:0]  vld;
  side_t              side [PROJ_STAGE+1];
  logic [15:0]        angle0;
  logic signed [15:0] sn, cs;
  corners_t           cor;
  res_t               res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width  <= '0;
      half_height <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HALF_WIDTH:  half_width  <= cfg.data[30:0];
        REG_HALF_HEIGHT: half_height <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  assign en         = !vld[STAGES-1] || result.ready;
  assign item.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], item.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle0                <= item.data.angle;
      side[0].action        <= item.data.action;
      side[0].pos_x         <= item.data.pos_x;
      side[0].pos_y         <= item.data.pos_y;
      side[0].first_axis_x  <= item.data.first_axis_x;
      side[0].first_axis_y  <= item.data.first_axis_y;
      side[0].second_axis_x <= item.data.second_axis_x;
      side[0].second_axis_y <= item.data.second_axis_y;
      for (int k = 1; k <= PROJ_STAGE; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign commit = en && vld[COMMIT_STAGE] && (side[COMMIT_STAGE].action == ACT_ROTATE);

  obbp_trig #(
    .TRIG_TABLE_BITS(TRIG_TABLE_BITS)
  ) u_trig (
    .clk   (clk),
    .en    (en),
    .angle (angle0),
    .sn    (sn),
    .cs    (cs)
  );

  obbp_corner u_corner (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .commit      (commit),
    .half_width  (half_width),
    .half_height (half_height),
    .sn          (sn),
    .cs          (cs),
    .cor         (cor)
  );

  obbp_proj u_proj (
    .clk   (clk),
    .en    (en),
    .side6 (side[PROJ_STAGE]),
    .cor   (cor),
    .res   (res)
  );

  assign result.valid = vld[STAGES-1];
  assign result.data  = res;

  logic signed [31:0] sa_min, sa_max, sb_min, sb_max;
  assign sa_min = res.span_a_min;
  assign sa_max = res.span_a_max;
  assign sb_min = res.span_b_min;
  assign sb_max = res.span_b_max;

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> vld[0])
    else $error("accepted item did not enter the pipeline");

  a_corners_hold: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(cor))
    else $error("corners changed without a rotate commit");

  a_mask_onehot: assert property (@(posedge clk) disable iff (rst)
    result.valid && (res.mask_a_min != 4'd0) |->
      $onehot(res.mask_a_min) && $onehot(res.mask_a_max) &&
      $onehot(res.mask_b_min) && $onehot(res.mask_b_max))
    else $error("projection masks not one-hot");

  a_span_order: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (sa_min <= sa_max) && (sb_min <= sb_max))
    else $error("span minimum above maximum");

endmodule

### hdl/obbp_trig.sv
module obbp_trig #(
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [15:0] sn,
  output logic signed [15:0] cs
);
  import obbp_pkg::*;

  localparam int          SH    = 16 - TRIG_TABLE_BITS;
  localparam logic [15:0] QMASK = 16'hFFFF << SH;

  // lane 0 is sine, lane 1 is cosine
  logic [15:0] q;
  logic [13:0] u;
  logic [14:0] z0 [2];
  logic        neg0 [2];
  logic [29:0] zz [2];

  logic [14:0] z1 [2], z2_1 [2];
  logic        neg1 [2];
  logic [25:0] m2 [2];

  logic [14:0] z2r [2], z2_2 [2];
  logic [13:0] t1_2 [2];
  logic        neg2 [2];
  logic [28:0] m3 [2];

  logic [14:0] z3 [2];
  logic [14:0] t2_3 [2];
  logic        neg3 [2];
  logic [29:0] m4 [2];
  logic signed [15:0] mag [2];

  always_comb begin
    q = angle & QMASK;
    u = q[13:0];
    z0[0]   = q[14] ? 15'(QUARTER - 15'(u)) : 15'(u);
    neg0[0] = q[15];
    // cosine sits one quadrant ahead
    z0[1]   = q[14] ? 15'(u) : 15'(QUARTER - 15'(u));
    neg0[1] = q[15] ^ q[14];
    for (int k = 0; k < 2; k++) begin
      zz[k] = 30'(z0[k]) * 30'(z0[k]);
      m2[k] = 26'(z2_1[k]) * 26'(SIN_C3);
      m3[k] = 29'(t1_2[k]) * 29'(z2_2[k]);
      m4[k] = 30'(z3[k]) * 30'(t2_3[k]);
      mag[k] = signed'({1'b0, m4[k][28:14]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        z1[k]   <= z0[k];
        z2_1[k] <= zz[k][28:14];
        neg1[k] <= neg0[k];

        z2r[k]  <= z1[k];
        z2_2[k] <= z2_1[k];
        t1_2[k] <= 14'(SIN_C2 - 15'(m2[k][25:14]));
        neg2[k] <= neg1[k];

        z3[k]   <= z2r[k];
        t2_3[k] <= 15'(SIN_C1 - 16'(m3[k][28:14]));
        neg3[k] <= neg2[k];
      end
      sn <= neg3[0] ? -mag[0] : mag[0];
      cs <= neg3[1] ? -mag[1] : mag[1];
    end
  end

endmodule

### hdl/obbp_corner.sv
module obbp_corner (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               commit,
  input  logic [30:0]        half_width,
  input  logic [30:0]        half_height,
  input  logic signed [15:0] sn,
  input  logic signed [15:0] cs,
  output obbp_pkg::corners_t cor
);
  import obbp_pkg::*;

  logic signed [31:0] ws, hs;
  logic signed [47:0] pwc, phs, pws, phc;

  assign ws = signed'({1'b0, half_width});
  assign hs = signed'({1'b0, half_height});

  always_ff @(posedge clk) begin
    if (en) begin
      pwc <= ws * cs;
      phs <= hs * sn;
      pws <= ws * sn;
      phc <= hs * cs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cor <= '0;
    end else if (commit) begin
      cor.b_x <= rnd14(50'(pwc) - 50'(phs));
      cor.b_y <= rnd14(50'(pws) + 50'(phc));
      cor.d_x <= rnd14(50'(pwc) + 50'(phs));
      cor.d_y <= rnd14(50'(pws) - 50'(phc));
    end
  end

endmodule

### hdl/obbp_proj.sv
module obbp_proj (
  input  logic               clk,
  input  logic               en,
  input  obbp_pkg::side_t    side6,
  input  obbp_pkg::corners_t cor,
  output obbp_pkg::res_t     res
);
  import obbp_pkg::*;

  localparam logic [3:0] HIT_A = 4'b0001;
  localparam logic [3:0] HIT_B = 4'b0010;
  localparam logic [3:0] HIT_C = 4'b0100;
  localparam logic [3:0] HIT_D = 4'b1000;

  typedef struct packed {
    logic signed [31:0] val;
    logic [3:0]         hot;
  } ext_t;

  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [31:0] bottom;
    logic signed [31:0] top;
  } bounds_t;

  function automatic logic signed [31:0] neg32(input logic signed [31:0] v);
    return (v == SAT_MIN) ? SAT_MAX : -v;
  endfunction

  function automatic logic signed [31:0] add_sat32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      return s[32] ? SAT_MIN : SAT_MAX;
    end
    return s[31:0];
  endfunction

  // ties keep the earlier corner
  function automatic ext_t pick_min(input logic signed [31:0] v0, v1, v2, v3);
    ext_t               r;
    logic signed [31:0] lo, hi;
    logic [3:0]         hlo, hhi;
    if (v1 < v0) begin
      lo = v1; hlo = HIT_B;
    end else begin
      lo = v0; hlo = HIT_A;
    end
    if (v3 < v2) begin
      hi = v3; hhi = HIT_D;
    end else begin
      hi = v2; hhi = HIT_C;
    end
    if (hi < lo) begin
      r.val = hi; r.hot = hhi;
    end else begin
      r.val = lo; r.hot = hlo;
    end
    return r;
  endfunction

  function automatic ext_t pick_max(input logic signed [31:0] v0, v1, v2, v3);
    ext_t               r;
    logic signed [31:0] lo, hi;
    logic [3:0]         hlo, hhi;
    if (v1 > v0) begin
      lo = v1; hlo = HIT_B;
    end else begin
      lo = v0; hlo = HIT_A;
    end
    if (v3 > v2) begin
      hi = v3; hhi = HIT_D;
    end else begin
      hi = v2; hhi = HIT_C;
    end
    if (hi > lo) begin
      r.val = hi; r.hot = hhi;
    end else begin
      r.val = lo; r.hot = hlo;
    end
    return r;
  endfunction

  // stage 7: the four corners, a = -d and c = -b
  logic signed [31:0] cx7 [4], cy7 [4];
  side_t              s7;
  // stage 8: offset corners and local bounds
  logic signed [31:0] ox8 [4], oy8 [4];
  bounds_t            loc8;
  side_t              s8;
  // stage 9: partial dot products and world bounds
  logic signed [47:0] m1x9 [4], m1y9 [4], m2x9 [4], m2y9 [4];
  bounds_t            wld9, loc9;
  action_t            act9;
  // stage 10: projections
  logic signed [31:0] p1_10 [4], p2_10 [4];
  bounds_t            wld10, loc10;
  action_t            act10;

  logic signed [31:0] px7, py7;
  logic signed [15:0] a1x, a1y, a2x, a2y;
  ext_t lx_mn, lx_mx, ly_mn, ly_mx;
  ext_t wx_mn, wx_mx, wy_mn, wy_mx;
  ext_t mn1, mx1, mn2, mx2;

  assign px7 = s7.pos_x;
  assign py7 = s7.pos_y;
  assign a1x = s8.first_axis_x;
  assign a1y = s8.first_axis_y;
  assign a2x = s8.second_axis_x;
  assign a2y = s8.second_axis_y;

  always_comb begin
    lx_mn = pick_min(cx7[0], cx7[1], cx7[2], cx7[3]);
    lx_mx = pick_max(cx7[0], cx7[1], cx7[2], cx7[3]);
    ly_mn = pick_min(cy7[0], cy7[1], cy7[2], cy7[3]);
    ly_mx = pick_max(cy7[0], cy7[1], cy7[2], cy7[3]);
    // saturating offset is monotonic, so world bounds are extremes of offset corners
    wx_mn = pick_min(ox8[0], ox8[1], ox8[2], ox8[3]);
    wx_mx = pick_max(ox8[0], ox8[1], ox8[2], ox8[3]);
    wy_mn = pick_min(oy8[0], oy8[1], oy8[2], oy8[3]);
    wy_mx = pick_max(oy8[0], oy8[1], oy8[2], oy8[3]);
    mn1 = pick_min(p1_10[0], p1_10[1], p1_10[2], p1_10[3]);
    mx1 = pick_max(p1_10[0], p1_10[1], p1_10[2], p1_10[3]);
    mn2 = pick_min(p2_10[0], p2_10[1], p2_10[2], p2_10[3]);
    mx2 = pick_max(p2_10[0], p2_10[1], p2_10[2], p2_10[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx7[0] <= neg32(cor.d_x);
      cy7[0] <= neg32(cor.d_y);
      cx7[1] <= cor.b_x;
      cy7[1] <= cor.b_y;
      cx7[2] <= neg32(cor.b_x);
      cy7[2] <= neg32(cor.b_y);
      cx7[3] <= cor.d_x;
      cy7[3] <= cor.d_y;
      s7     <= side6;

      for (int k = 0; k < 4; k++) begin
        ox8[k] <= add_sat32(cx7[k], px7);
        oy8[k] <= add_sat32(cy7[k], py7);
      end
      loc8.left   <= lx_mn.val;
      loc8.right  <= lx_mx.val;
      loc8.bottom <= ly_mn.val;
      loc8.top    <= ly_mx.val;
      s8          <= s7;

      for (int k = 0; k < 4; k++) begin
        m1x9[k] <= ox8[k] * a1x;
        m1y9[k] <= oy8[k] * a1y;
        m2x9[k] <= ox8[k] * a2x;
        m2y9[k] <= oy8[k] * a2y;
      end
      wld9.left   <= wx_mn.val;
      wld9.right  <= wx_mx.val;
      wld9.bottom <= wy_mn.val;
      wld9.top    <= wy_mx.val;
      loc9        <= loc8;
      act9        <= s8.action;

      for (int k = 0; k < 4; k++) begin
        p1_10[k] <= rnd14(50'(m1x9[k]) + 50'(m1y9[k]));
        p2_10[k] <= rnd14(50'(m2x9[k]) + 50'(m2y9[k]));
      end
      wld10 <= wld9;
      loc10 <= loc9;
      act10 <= act9;

      if (act10 == ACT_PROJECT) begin
        res.span_a_min   <= mn1.val;
        res.span_a_max   <= mx1.val;
        res.span_b_min   <= mn2.val;
        res.span_b_max   <= mx2.val;
        res.mask_a_min   <= mn1.hot;
        res.mask_a_max   <= mx1.hot;
        res.mask_b_min   <= mn2.hot;
        res.mask_b_max   <= mx2.hot;
        res.local_left   <= '0;
        res.local_right  <= '0;
        res.local_bottom <= '0;
        res.local_top    <= '0;
      end else begin
        res.span_a_min   <= wld10.left;
        res.span_a_max   <= wld10.right;
        res.span_b_min   <= wld10.bottom;
        res.span_b_max   <= wld10.top;
        res.mask_a_min   <= '0;
        res.mask_a_max   <= '0;
        res.mask_b_min   <= '0;
        res.mask_b_max   <= '0;
        res.local_left   <= loc10.left;
        res.local_right  <= loc10.right;
        res.local_bottom <= loc10.bottom;
        res.local_top    <= loc10.top;
      end
    end
  end

endmodule
